// ===== design/ohs_pkg.sv =====
`timescale 1ns / 1ps

package ohs_pkg;

  // Number of slots the memories hold; the slots in use are a power of two up to this.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned LIVE_W      = 9;
  localparam int unsigned LG_W        = 4;
  localparam int unsigned OP_W        = 2;

  localparam logic [LG_W-1:0] LG_MIN   = LG_W'(2);
  localparam logic [LG_W-1:0] LG_RESET = LG_W'(8);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_ERASE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_PRESENT = 2'd1,
    MARK_DELETED = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_PUSH
  } ctrl_state_e;

  typedef struct packed {
    logic en;
    idx_t addr;
  } slot_rd_t;

  typedef struct packed {
    logic              en;
    idx_t              addr;
    mark_e             mark;
    logic [KEY_W-1:0]  key;
  } slot_wr_t;

  typedef struct packed {
    logic              was_present;
    logic              status;
    logic [LIVE_W-1:0] live_entries;
  } result_t;

  // Mask of the slots in use: the size is raised to the minimum and capped at the depth.
  function automatic idx_t cap_mask(input logic [LG_W-1:0] lg);
    int unsigned eff;
    idx_t        m;
    eff = (lg < LG_MIN) ? int'(LG_MIN) : int'(lg);
    if (eff > IDX_W) eff = IDX_W;
    for (int i = 0; i < IDX_W; i++) begin
      m[i] = (i < eff);
    end
    return m;
  endfunction

endpackage

// ===== design/ohs_slot_mem.sv =====
`timescale 1ns / 1ps

module ohs_slot_mem
  import ohs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slot_rd_t         rd_i,
  input  slot_wr_t         wr_i,
  output mark_e            rd_mark_o,
  output logic [KEY_W-1:0] rd_key_o
);

  logic [1:0]       mark_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] key_mem  [TABLE_DEPTH];
  logic             valid_q  [TABLE_DEPTH];

  logic [1:0]       rd_mark_q;
  logic [KEY_W-1:0] rd_key_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mark_mem[wr_i.addr] <= wr_i.mark;
      key_mem[wr_i.addr]  <= wr_i.key;
    end
    if (rd_i.en) begin
      rd_mark_q <= mark_mem[rd_i.addr];
      rd_key_q  <= key_mem[rd_i.addr];
    end
  end

  // A slot never written since reset reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) valid_q[i] <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) valid_q[wr_i.addr] <= 1'b1;
      if (rd_i.en) rd_valid_q <= valid_q[rd_i.addr];
    end
  end

  assign rd_mark_o = rd_valid_q ? mark_e'(rd_mark_q) : MARK_EMPTY;
  assign rd_key_o  = rd_key_q;

endmodule

// ===== design/ohs_ctrl.sv =====
`timescale 1ns / 1ps

module ohs_ctrl
  import ohs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         op_i,
  input  logic signed [KEY_W-1:0] key_i,
  input  logic [LG_W-1:0]         cfg_lg_i,
  output slot_rd_t                rd_o,
  output slot_wr_t                wr_o,
  input  mark_e                   rd_mark_i,
  input  logic [KEY_W-1:0]        rd_key_i,
  output logic                    res_valid_o,
  output result_t                 res_o,
  input  logic                    res_ready_i
);

  ctrl_state_e state_q, state_d;

  logic [OP_W-1:0]  op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  idx_t             mask_q, mask_d;
  idx_t             probe_q, probe_d;
  idx_t             cnt_q, cnt_d;
  logic             del_seen_q, del_seen_d;
  idx_t             del_at_q, del_at_d;
  logic [LIVE_W-1:0] live_q, live_d;
  result_t          res_q, res_d;

  logic accept;
  logic hit;
  logic finish;
  idx_t next_probe;
  idx_t cur_mask;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cur_mask   = cap_mask(cfg_lg_i);
  assign hit        = (rd_mark_i == MARK_PRESENT) && (rd_key_i == key_q);
  assign finish     = hit || (rd_mark_i == MARK_EMPTY) || (cnt_q == mask_q);
  assign next_probe = (probe_q + idx_t'(1)) & mask_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_CMP;
      S_CMP:  if (finish) state_d = S_PUSH;
      S_PUSH: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d       = op_q;
    key_d      = key_q;
    mask_d     = mask_q;
    probe_d    = probe_q;
    cnt_d      = cnt_q;
    del_seen_d = del_seen_q;
    del_at_d   = del_at_q;
    live_d     = live_q;
    res_d      = res_q;
    rd_o       = '{en: 1'b0, addr: probe_q};
    wr_o       = '{en: 1'b0, addr: probe_q, mark: MARK_PRESENT, key: key_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d       = op_i;
          key_d      = key_i;
          mask_d     = cur_mask;
          probe_d    = key_i[IDX_W-1:0] & cur_mask;
          cnt_d      = '0;
          del_seen_d = 1'b0;
          rd_o       = '{en: 1'b1, addr: key_i[IDX_W-1:0] & cur_mask};
        end
      end
      S_CMP: begin
        if (finish) begin
          res_d.was_present = hit;
          res_d.status      = 1'b0;
          if (op_q == OP_INSERT && !hit) begin
            if (del_seen_q) begin
              wr_o.en   = 1'b1;
              wr_o.addr = del_at_q;
            end else if (rd_mark_i == MARK_DELETED || rd_mark_i == MARK_EMPTY) begin
              wr_o.en = 1'b1;
            end else begin
              res_d.status = 1'b1;
            end
            if (wr_o.en) live_d = live_q + LIVE_W'(1);
          end else if (op_q == OP_ERASE && hit) begin
            wr_o.en   = 1'b1;
            wr_o.mark = MARK_DELETED;
            if (live_q != '0) live_d = live_q - LIVE_W'(1);
          end
          res_d.live_entries = live_d;
        end else begin
          if (rd_mark_i == MARK_DELETED && !del_seen_q) begin
            del_seen_d = 1'b1;
            del_at_d   = probe_q;
          end
          probe_d = next_probe;
          cnt_d   = cnt_q + idx_t'(1);
          rd_o    = '{en: 1'b1, addr: next_probe};
        end
      end
      S_PUSH: ;
      default: ;
    endcase
  end

  assign res_valid_o = (state_q == S_PUSH);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      live_q     <= '0;
      del_seen_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      live_q     <= live_d;
      del_seen_q <= del_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    mask_q   <= mask_d;
    probe_q  <= probe_d;
    cnt_q    <= cnt_d;
    del_at_q <= del_at_d;
    res_q    <= res_d;
  end

  // The walk never visits more slots than are in use.
  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> cnt_q <= mask_q)
    else $error("probe walk exceeded the slots in use");

  // Slot memory is written only on the cycle that ends a walk.
  a_write_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (state_q == S_CMP && finish))
    else $error("slot write outside the end of a walk");

  // A finished walk always hands over a result next.
  a_finish_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && finish) |=> state_q == S_PUSH)
    else $error("finished walk did not produce a result");

  // The live count never exceeds the number of slots.
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= LIVE_W'(TABLE_DEPTH))
    else $error("live count above table depth");

endmodule

// ===== design/open_address_hash_set_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_stall_o  operation_i, key_i
// result    out        out_valid_o / out_stall_i was_present_o, status_o, live_entries_o
// config    in         cfg_we_i                 cfg_wdata_i (table_size_log2)
//
// One transaction is handled at a time. The block accepts it and issues the home-slot read,
// compares each probed slot in turn (the slot memory gives one read a cycle), and then
// hands the result to the output register.
// Reset clears the slot valid bits at once, so every slot reads as empty right after reset.
// The output register lets a new transaction be accepted while a result is still stalled.

module open_address_hash_set_top
  import ohs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [LG_W-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         operation_i,
  input  logic signed [KEY_W-1:0] key_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    was_present_o,
  output logic                    status_o,
  output logic [LIVE_W-1:0]       live_entries_o
);

  logic [LG_W-1:0]  cfg_lg_q;
  slot_rd_t         rd;
  slot_wr_t         wr;
  mark_e            rd_mark;
  logic [KEY_W-1:0] rd_key;
  logic             res_valid;
  result_t          res;
  logic             res_ready;
  logic             out_valid_q;
  result_t          out_q;

  // The user must rewrite the size register only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_lg_q <= LG_RESET;
    end else if (cfg_we_i) begin
      cfg_lg_q <= cfg_wdata_i;
    end
  end

  ohs_slot_mem u_slot_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .wr_i      (wr),
    .rd_mark_o (rd_mark),
    .rd_key_o  (rd_key)
  );

  ohs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (operation_i),
    .key_i       (key_i),
    .cfg_lg_i    (cfg_lg_q),
    .rd_o        (rd),
    .wr_o        (wr),
    .rd_mark_i   (rd_mark),
    .rd_key_i    (rd_key),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign out_valid_o    = out_valid_q;
  assign was_present_o  = out_q.was_present;
  assign status_o       = out_q.status;
  assign live_entries_o = out_q.live_entries;

endmodule
